// ===== design/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/ssms_pkg.sv =====
// types, codes and constants of the slot switcher
package ssms_pkg;

	localparam int NUM_SLOTS_DEF = 10;
	localparam int SLOT_W = 4;
	localparam int MASK_W = 16;

	localparam logic [2:0] CMD_CREATE = 3'd0;
	localparam logic [2:0] CMD_NEXT   = 3'd1;
	localparam logic [2:0] CMD_PREV   = 3'd2;
	localparam logic [2:0] CMD_LAST   = 3'd3;
	localparam logic [2:0] CMD_GOTO   = 3'd4;
	localparam logic [2:0] CMD_CLOSE  = 3'd5;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_OTHER   = 3'd1;
	localparam logic [2:0] ST_ABSENT     = 3'd2;
	localparam logic [2:0] ST_NO_FREE    = 3'd3;
	localparam logic [2:0] ST_ALLOC_FAIL = 3'd4;
	localparam logic [2:0] ST_NONE_LEFT  = 3'd5;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [SLOT_W-1:0] target;
		logic              alloc_ok;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] current_slot;
		logic [2:0]        status;
		logic              redraw;
		logic [MASK_W-1:0] occupied_mask;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} stk_entry_t;

	typedef struct packed {
		logic              push;
		logic              drop;
		logic [SLOT_W-1:0] key;
	} stk_op_t;

endpackage

// ===== design/ssms_cell.sv =====
// one entry of the recently-used stack
module ssms_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ssms_pkg::stk_op_t    op,
	input  ssms_pkg::stk_entry_t left,
	input  ssms_pkg::stk_entry_t right,
	input  logic                chain_in,
	output logic                chain_out,
	output ssms_pkg::stk_entry_t ent
);

	ssms_pkg::stk_entry_t ent_q;
	logic same;
	logic hit;

	assign same = (ent_q.slot == op.key);
	// push stops at a free entry or at the entering slot, drop at the removed slot
	assign hit = op.push ? (!ent_q.valid || same) : (ent_q.valid && same);
	assign chain_out = chain_in | hit;
	assign ent = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (op.push && !chain_in) begin
			ent_q <= left;
		end else if (op.drop && chain_out) begin
			ent_q <= right;
		end
	end

endmodule

// ===== design/ssms_ctrl.sv =====
// command sequencer, occupancy map and slot scan
module ssms_ctrl #(
	parameter int NUM_SLOTS = ssms_pkg::NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ssms_pkg::req_t       req,
	input  ssms_pkg::stk_entry_t top,
	output ssms_pkg::stk_op_t    op,
	output logic [ssms_pkg::SLOT_W-1:0] leave,
	output logic                 done,
	output ssms_pkg::rsp_t       rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SW = ssms_pkg::SLOT_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_SEL  = 5'b00100,
		S_DROP = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [2:0]           cmd_q;
	logic [SW-1:0]        tgt_q;
	logic                 alloc_q;
	logic [NUM_SLOTS-1:0] used_q;
	logic [SW-1:0]        cur_q;
	logic [SW-1:0]        sel_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [2:0]           status_q;
	logic                 redraw_q;
	logic                 done_q;
	ssms_pkg::rsp_t       rsp_q;

	logic             req_ok;
	logic             scan_create;
	logic             hit;
	logic [IDX_W-1:0] cnt_last;
	logic             sel_used;

	function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] v);
		return (v == LAST) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] dec(input logic [IDX_W-1:0] v);
		return (v == '0) ? LAST : v - 1'b1;
	endfunction

	assign req_ok = ({1'b0, req.target} < (SW + 1)'(NUM_SLOTS)) &&
		used_q[req.target[IDX_W-1:0]];
	assign scan_create = (cmd_q == ssms_pkg::CMD_CREATE);
	assign hit = scan_create ? !used_q[ptr_q] : used_q[ptr_q];
	assign cnt_last = scan_create ? IDX_W'(NUM_SLOTS - 1) : IDX_W'(NUM_SLOTS - 2);
	assign sel_used = used_q[sel_q[IDX_W-1:0]];

	always_comb begin
		op.push = (state_q == S_SEL) && sel_used && (sel_q != cur_q);
		op.drop = (state_q == S_DROP);
		op.key  = (state_q == S_DROP) ? tgt_q : sel_q;
	end

	assign leave = cur_q;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			tgt_q    <= '0;
			alloc_q  <= 1'b0;
			used_q   <= NUM_SLOTS'(1);
			cur_q    <= '0;
			sel_q    <= '0;
			ptr_q    <= '0;
			cnt_q    <= '0;
			status_q <= ssms_pkg::ST_OK;
			redraw_q <= 1'b0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= req.cmd;
						tgt_q   <= req.target;
						alloc_q <= req.alloc_ok;
						cnt_q   <= '0;
						unique case (req.cmd)
							ssms_pkg::CMD_CREATE: begin
								ptr_q    <= '0;
								status_q <= ssms_pkg::ST_OK;
								redraw_q <= 1'b0;
								state_q  <= S_SCAN;
							end
							ssms_pkg::CMD_NEXT: begin
								ptr_q    <= inc(cur_q[IDX_W-1:0]);
								status_q <= ssms_pkg::ST_OK;
								redraw_q <= 1'b0;
								state_q  <= S_SCAN;
							end
							ssms_pkg::CMD_PREV: begin
								ptr_q    <= dec(cur_q[IDX_W-1:0]);
								status_q <= ssms_pkg::ST_OK;
								redraw_q <= 1'b0;
								state_q  <= S_SCAN;
							end
							ssms_pkg::CMD_LAST: begin
								if (!top.valid) begin
									status_q <= ssms_pkg::ST_NO_OTHER;
									redraw_q <= 1'b0;
									state_q  <= S_FIN;
								end else begin
									sel_q    <= top.slot;
									status_q <= ssms_pkg::ST_OK;
									redraw_q <= 1'b1;
									state_q  <= S_SEL;
								end
							end
							ssms_pkg::CMD_GOTO: begin
								if (!req_ok) begin
									status_q <= ssms_pkg::ST_ABSENT;
									redraw_q <= 1'b0;
									state_q  <= S_FIN;
								end else begin
									sel_q    <= req.target;
									status_q <= ssms_pkg::ST_OK;
									redraw_q <= 1'b1;
									state_q  <= S_SEL;
								end
							end
							ssms_pkg::CMD_CLOSE: begin
								if (!req_ok) begin
									status_q <= ssms_pkg::ST_ABSENT;
									redraw_q <= 1'b0;
									state_q  <= S_FIN;
								end else begin
									used_q[req.target[IDX_W-1:0]] <= 1'b0;
									status_q <= ssms_pkg::ST_OK;
									if (top.valid) begin
										sel_q    <= top.slot;
										redraw_q <= 1'b1;
										state_q  <= S_SEL;
									end else begin
										ptr_q    <= inc(req.target[IDX_W-1:0]);
										redraw_q <= 1'b0;
										state_q  <= S_SCAN;
									end
								end
							end
							default: begin
								status_q <= ssms_pkg::ST_OK;
								redraw_q <= 1'b0;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (scan_create && !alloc_q) begin
							status_q <= ssms_pkg::ST_ALLOC_FAIL;
							state_q  <= S_FIN;
						end else begin
							if (scan_create) begin
								used_q[ptr_q] <= 1'b1;
							end
							sel_q    <= SW'(ptr_q);
							redraw_q <= 1'b1;
							state_q  <= S_SEL;
						end
					end else if (cnt_q == cnt_last) begin
						priority if (scan_create) begin
							status_q <= ssms_pkg::ST_NO_FREE;
						end else if (cmd_q == ssms_pkg::CMD_CLOSE) begin
							status_q <= ssms_pkg::ST_NONE_LEFT;
						end else begin
							status_q <= ssms_pkg::ST_NO_OTHER;
						end
						state_q <= S_FIN;
					end else begin
						ptr_q <= (cmd_q == ssms_pkg::CMD_PREV) ? dec(ptr_q) : inc(ptr_q);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SEL: begin
					if (sel_used) begin
						cur_q <= sel_q;
					end
					state_q <= (cmd_q == ssms_pkg::CMD_CLOSE) ? S_DROP : S_FIN;
				end
				S_DROP: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					rsp_q.current_slot  <= cur_q;
					rsp_q.status        <= status_q;
					rsp_q.redraw        <= redraw_q;
					rsp_q.occupied_mask <= ssms_pkg::MASK_W'(used_q);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/session_slot_mru_switcher.sv =====
// top level: slot switcher with a recently-used stack built from a row of cells
// A command is taken when start is high and busy is low; its result is registered on rsp and
// held, with done high for one cycle, and cannot be held off. Go-to and last used pass through
// the select and finish states, close also the drop state, and unused codes or rejected targets
// go straight to finish. Create, next, previous and close with an empty stack first scan the
// occupancy map one slot per cycle, create over every slot, the others over all but their start.
// busy drops in the cycle that carries done, so the next request may come with it.
module session_slot_mru_switcher #(
	parameter int NUM_SLOTS = ssms_pkg::NUM_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ssms_pkg::req_t req,
	output logic           done,
	output ssms_pkg::rsp_t rsp
);

	localparam int DEPTH = NUM_SLOTS - 1;

	ssms_pkg::stk_op_t              op;
	logic [ssms_pkg::SLOT_W-1:0]    leave;
	ssms_pkg::stk_entry_t           ent [DEPTH];
	logic                           chain [DEPTH];

	ssms_ctrl #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.top   (ent[0]),
		.op    (op),
		.leave (leave),
		.done  (done),
		.rsp   (rsp)
	);

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		ssms_pkg::stk_entry_t left_w;
		ssms_pkg::stk_entry_t right_w;
		logic                 cin_w;

		if (k == 0) begin : g_head
			assign left_w = '{valid: 1'b1, slot: leave};
			assign cin_w  = 1'b0;
		end else begin : g_body
			assign left_w = ent[k-1];
			assign cin_w  = chain[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid
			assign right_w = ent[k+1];
		end

		ssms_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.left     (left_w),
			.right    (right_w),
			.chain_in (cin_w),
			.chain_out(chain[k]),
			.ent      (ent[k])
		);
	end

endmodule

// ===== design/ssms_checker.sv =====
// port checker for the slot switcher and its bind
`include "assert_macros.svh"

module ssms_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input ssms_pkg::rsp_t rsp
);

	// a taken request keeps the block busy
	`ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// a result ends a busy stretch
	`ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy)

	// one result per request
	`ASSERT_NXT(a_done_single, clk, arst_n, done, !done)

	// a redraw only comes with a good status
	`ASSERT_IMP(a_redraw_ok, clk, arst_n, done && rsp.redraw, rsp.status == ssms_pkg::ST_OK)

	`ASSERT_IMP(a_status_code, clk, arst_n, done, rsp.status <= ssms_pkg::ST_NONE_LEFT)

endmodule

bind session_slot_mru_switcher ssms_checker u_ssms_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
